FILE: sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

FILE: sv/qte_pkg.sv
package qte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;

    localparam int ZW      = ANGLE_BITS + 2;   // angle accumulator
    localparam int CW      = 40;               // CORDIC x/y
    localparam int SW      = 36;               // product sums
    localparam int SP_W    = 29;               // unclamped asin argument
    localparam int NB      = 58;               // sqrt radicand, even width
    localparam int SQ_STEPS = NB / 2;
    localparam int RT_W    = SQ_STEPS;
    localparam int REM_W   = RT_W + 3;
    localparam int STEP_W  = 5;
    localparam int NSTG    = 3 + SQ_STEPS + CORDIC_STEPS + 1;

    localparam logic signed [SW-1:0] ONE = SW'(64'sd268435456);

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_TURN32 [31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_clamped;
    } euler_t;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] yz;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] wz;
        logic signed [31:0] xy;
        logic signed [31:0] zz;
        logic signed [31:0] wy;
        logic signed [31:0] zx;
    } prod_t;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic signed [SW-1:0] sp;
    } sums_t;

    typedef struct packed {
        logic signed [SW-1:0]   sr;
        logic signed [SW-1:0]   cr;
        logic signed [SW-1:0]   sy;
        logic signed [SW-1:0]   cy;
        logic signed [SP_W-1:0] sp;
        logic                   pos;
        logic                   neg;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
        logic [NB-1:0]    bits;
        side_t            side;
    } sq_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
        logic  roll_zero;
        logic  yaw_zero;
        logic  pos;
        logic  neg;
    } rot_t;

    function automatic logic signed [ZW-1:0] step_angle(input logic [STEP_W-1:0] i);
        logic [32:0] t;
        logic [32:0] r;
        t = {1'b0, ATAN_TURN32[i]};
        if (ANGLE_BITS == 32)
            r = t;
        else
            r = (t + (33'd1 << (32 - ANGLE_BITS - 1))) >> (32 - ANGLE_BITS);
        return ZW'(r);
    endfunction

    // Quadrant fold for x < 0 so the rotations converge.
    function automatic lane_t prerotate(input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] x);
        lane_t r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y;
                r.y = -x;
                r.z = ZW'(1) <<< (ANGLE_BITS - 2);
            end
            else begin
                r.x = -y;
                r.y = x;
                r.z = -(ZW'(1) <<< (ANGLE_BITS - 2));
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] to_out16(input logic signed [ZW-1:0] a);
        logic signed [ZW+15:0] e;
        logic signed [ZW+15:0] r;
        e = {{16{a[ZW-1]}}, a};
        if (ANGLE_BITS == 16)
            r = e;
        else if (ANGLE_BITS > 16)
            r = (e + ((ZW+16)'(1) <<< (ANGLE_BITS - 17))) >>> (ANGLE_BITS - 16);
        else
            r = e <<< (16 - ANGLE_BITS);
        return r[15:0];
    endfunction

endpackage

FILE: sv/qte_sqrt_cell.sv
// One root bit of the integer square root from two radicand bits; side data rides along.
module qte_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  qte_pkg::sq_t  d,
    output qte_pkg::sq_t  q
);

    logic [qte_pkg::REM_W-1:0] r2;
    logic [qte_pkg::REM_W-1:0] trial;
    logic                      ge;
    qte_pkg::sq_t              q_next;
    qte_pkg::sq_t              q_reg;

    always_comb
    begin
        r2    = {d.rem[qte_pkg::REM_W-3:0], d.bits[qte_pkg::NB-1 -: 2]};
        trial = {{(qte_pkg::REM_W - qte_pkg::RT_W - 2){1'b0}}, d.root, 2'b01};
        ge    = (r2 >= trial);
        q_next.rem  = ge ? (r2 - trial) : r2;
        q_next.root = {d.root[qte_pkg::RT_W-2:0], ge};
        q_next.bits = {d.bits[qte_pkg::NB-3:0], 2'b00};
        q_next.side = d.side;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: sv/qte_cordic_cell.sv
// One vectoring micro-rotation for the roll, pitch and yaw lanes.
module qte_cordic_cell (
    input  logic                        clk,
    input  logic                        en,
    input  logic [qte_pkg::STEP_W-1:0]  step,
    input  qte_pkg::rot_t               d,
    output qte_pkg::rot_t               q
);

    function automatic qte_pkg::lane_t rotate(input qte_pkg::lane_t l,
                                              input logic [qte_pkg::STEP_W-1:0] s);
        logic signed [qte_pkg::CW-1:0] xs;
        logic signed [qte_pkg::CW-1:0] ys;
        logic signed [qte_pkg::ZW-1:0] a;
        qte_pkg::lane_t                r;
        xs = l.x >>> s;
        ys = l.y >>> s;
        a  = qte_pkg::step_angle(s);
        if (l.y > 0) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + a;
        end
        else begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - a;
        end
        return r;
    endfunction

    qte_pkg::rot_t q_next;
    qte_pkg::rot_t q_reg;

    always_comb
    begin
        q_next           = d;
        q_next.roll      = rotate(d.roll, step);
        q_next.pitch     = rotate(d.pitch, step);
        q_next.yaw       = rotate(d.yaw, step);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: sv/quaternion_to_euler_angles_core.sv
// Quaternion (Q1.14) to Z-Y-X Euler angles (binary angles, 32768 = pi).
//
// Input channel quat_valid / quat_stall / quat carries w, x, y, z.
// Output channel euler_valid / euler_stall / euler carries roll, pitch, yaw
// and the pitch clamp flag. A transfer happens when valid is high and stall
// is low. Every input transfer yields exactly one output transfer, in order.
//
// Stages: products, sums, clamp test and square, 29 root-digit cells, one
// CORDIC cell per step with the three angles in parallel, and the output
// register. Throughput is one item per clock while the output is not held
// off; the chain of cells advances as a whole.
//
// While euler_valid is high and euler_stall is high the whole chain holds and
// quat_stall is raised; empty slots ahead of the output do not fill meanwhile.
// Reset clears every valid bit; payload registers are not reset. No state is
// kept between items.
`include "assert_macros.svh"

module quaternion_to_euler_angles_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             quat_valid,
    output logic             quat_stall,
    input  qte_pkg::quat_t   quat,
    output logic             euler_valid,
    input  logic             euler_stall,
    output qte_pkg::euler_t  euler
);

    logic                          en;
    logic                          accept;
    logic [qte_pkg::NSTG-1:0]      valid_reg;
    logic [qte_pkg::NSTG-1:0]      valid_next;

    qte_pkg::prod_t                prod_reg;
    qte_pkg::prod_t                prod_next;
    qte_pkg::sums_t                sums_reg;
    qte_pkg::sums_t                sums_next;
    qte_pkg::sq_t                  sq [qte_pkg::SQ_STEPS+1];
    qte_pkg::sq_t                  sq0_next;
    qte_pkg::rot_t                 rot [qte_pkg::CORDIC_STEPS+1];
    qte_pkg::euler_t               euler_reg;
    qte_pkg::euler_t               euler_next;

    // Chain advances unless the finished result is held off.
    assign en          = !(valid_reg[qte_pkg::NSTG-1] && euler_stall);
    assign accept      = quat_valid && en;
    assign quat_stall  = !en;
    assign euler_valid = valid_reg[qte_pkg::NSTG-1];
    assign euler       = euler_reg;

    assign valid_next = {valid_reg[qte_pkg::NSTG-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // Stage 1: the nine distinct products, exact.
    always_comb
    begin
        prod_next.wx = quat.quat_w * quat.quat_x;
        prod_next.yz = quat.quat_y * quat.quat_z;
        prod_next.xx = quat.quat_x * quat.quat_x;
        prod_next.yy = quat.quat_y * quat.quat_y;
        prod_next.wz = quat.quat_w * quat.quat_z;
        prod_next.xy = quat.quat_x * quat.quat_y;
        prod_next.zz = quat.quat_z * quat.quat_z;
        prod_next.wy = quat.quat_w * quat.quat_y;
        prod_next.zx = quat.quat_z * quat.quat_x;
    end

    // Stage 2: operands of the three angle functions, 1.0 = 2^28.
    always_comb
    begin
        sums_next.sr = (qte_pkg::SW'(prod_reg.wx) + qte_pkg::SW'(prod_reg.yz)) <<< 1;
        sums_next.cr = qte_pkg::ONE
                     - ((qte_pkg::SW'(prod_reg.xx) + qte_pkg::SW'(prod_reg.yy)) <<< 1);
        sums_next.sy = (qte_pkg::SW'(prod_reg.wz) + qte_pkg::SW'(prod_reg.xy)) <<< 1;
        sums_next.cy = qte_pkg::ONE
                     - ((qte_pkg::SW'(prod_reg.yy) + qte_pkg::SW'(prod_reg.zz)) <<< 1);
        sums_next.sp = (qte_pkg::SW'(prod_reg.wy) - qte_pkg::SW'(prod_reg.zx)) <<< 1;
    end

    // Stage 3: clamp test and radicand 2^56 - s^2 (s below 2^28 when used).
    always_comb
    begin
        logic signed [qte_pkg::SW-1:0] mag;
        logic [27:0]                   m28;
        logic [55:0]                   sq56;
        logic [56:0]                   rad;
        mag  = sums_reg.sp[qte_pkg::SW-1] ? -sums_reg.sp : sums_reg.sp;
        m28  = mag[27:0];
        sq56 = m28 * m28;
        rad  = (57'd1 << 56) - {1'b0, sq56};
        sq0_next.rem       = '0;
        sq0_next.root      = '0;
        sq0_next.bits      = {{(qte_pkg::NB-57){1'b0}}, rad};
        sq0_next.side.sr   = sums_reg.sr;
        sq0_next.side.cr   = sums_reg.cr;
        sq0_next.side.sy   = sums_reg.sy;
        sq0_next.side.cy   = sums_reg.cy;
        sq0_next.side.sp   = sums_reg.sp[qte_pkg::SP_W-1:0];
        sq0_next.side.pos  = (sums_reg.sp >= qte_pkg::ONE);
        sq0_next.side.neg  = (sums_reg.sp <= -qte_pkg::ONE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sums_reg <= sums_next;
            sq[0]    <= sq0_next;
        end
    end

    // Root-digit chain.
    for (genvar k = 0; k < qte_pkg::SQ_STEPS; k++)
    begin : g_sqrt
        qte_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (sq[k]),
            .q   (sq[k+1])
        );
    end

    // Fold quadrants and start the three CORDIC lanes.
    always_comb
    begin
        logic signed [qte_pkg::CW-1:0] sr;
        logic signed [qte_pkg::CW-1:0] cr;
        logic signed [qte_pkg::CW-1:0] sy;
        logic signed [qte_pkg::CW-1:0] cy;
        logic signed [qte_pkg::CW-1:0] sp;
        logic signed [qte_pkg::CW-1:0] cp;
        qte_pkg::side_t                s;
        s  = sq[qte_pkg::SQ_STEPS].side;
        sr = qte_pkg::CW'(s.sr);
        cr = qte_pkg::CW'(s.cr);
        sy = qte_pkg::CW'(s.sy);
        cy = qte_pkg::CW'(s.cy);
        sp = qte_pkg::CW'(s.sp);
        cp = $signed({{(qte_pkg::CW - qte_pkg::RT_W){1'b0}}, sq[qte_pkg::SQ_STEPS].root});
        rot[0].roll      = qte_pkg::prerotate(sr, cr);
        rot[0].pitch     = qte_pkg::prerotate(sp, cp);
        rot[0].yaw       = qte_pkg::prerotate(sy, cy);
        rot[0].roll_zero = (s.sr == '0) && (s.cr == '0);
        rot[0].yaw_zero  = (s.sy == '0) && (s.cy == '0);
        rot[0].pos       = s.pos;
        rot[0].neg       = s.neg;
    end

    for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        qte_cordic_cell u_cell (
            .clk  (clk),
            .en   (en),
            .step (qte_pkg::STEP_W'(i)),
            .d    (rot[i]),
            .q    (rot[i+1])
        );
    end

    // Output: rounding to 16 bits, zero vectors, pitch saturation.
    always_comb
    begin
        qte_pkg::rot_t r;
        r = rot[qte_pkg::CORDIC_STEPS];
        euler_next.roll_angle = r.roll_zero ? 16'sd0 : qte_pkg::to_out16(r.roll.z);
        euler_next.yaw_angle  = r.yaw_zero  ? 16'sd0 : qte_pkg::to_out16(r.yaw.z);
        if (r.pos)
            euler_next.pitch_angle = 16'sd16384;
        else if (r.neg)
            euler_next.pitch_angle = -16'sd16384;
        else
            euler_next.pitch_angle = qte_pkg::to_out16(r.pitch.z);
        euler_next.pitch_clamped = r.pos || r.neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            euler_reg <= euler_next;
    end

    `ASSERT_NEXT(a_accept_enters, clk, rst_n, quat_valid && !quat_stall, valid_reg[0])
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, euler_valid && euler_stall, $stable(valid_reg))
    `ASSERT_IMPLIES(a_clamp_value, clk, rst_n, euler_valid && euler.pitch_clamped, euler.pitch_angle == 16'sd16384 || euler.pitch_angle == -16'sd16384)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Expected Euler angles for every accepted quaternion, checked in order.
class euler_scoreboard;
    qte_pkg::euler_t pending[$];
    int              mismatches;

    static function longint shr_floor(longint v, int k);
        return v >>> k;
    endfunction

    static function longint step_ang(int i);
        longint t;
        int     sh;
        sh = 32 - qte_pkg::ANGLE_BITS;
        t  = longint'(qte_pkg::ATAN_TURN32[i]);
        if (sh == 0)
            return t;
        return (t + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // vectoring CORDIC, ANGLE_BITS-bit binary angle
    static function longint vector_angle(longint yv, longint xv);
        longint zacc;
        longint t;
        longint xs;
        longint ys;
        zacc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -t;
                zacc = longint'(1) << (qte_pkg::ANGLE_BITS - 2);
            end
            else begin
                xv = -yv;
                yv = t;
                zacc = -(longint'(1) << (qte_pkg::ANGLE_BITS - 2));
            end
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 31; i++) begin
            xs = shr_floor(xv, i);
            ys = shr_floor(yv, i);
            if (yv > 0) begin
                xv = xv + ys;
                yv = yv - xs;
                zacc = zacc + step_ang(i);
            end
            else begin
                xv = xv - ys;
                yv = yv + xs;
                zacc = zacc - step_ang(i);
            end
        end
        return zacc;
    endfunction

    static function logic [15:0] angle16(longint a);
        longint r;
        int     sh;
        if (qte_pkg::ANGLE_BITS >= 16) begin
            sh = qte_pkg::ANGLE_BITS - 16;
            r = (sh == 0) ? a : ((a + (longint'(1) << (sh - 1))) >>> sh);
        end
        else
            r = a * (longint'(1) << (16 - qte_pkg::ANGLE_BITS));
        return r[15:0];
    endfunction

    static function longint root_floor(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    static function qte_pkg::euler_t predict_angles(qte_pkg::quat_t q);
        qte_pkg::euler_t e;
        longint w;
        longint x;
        longint y;
        longint z;
        longint unity;
        longint sr;
        longint cr;
        longint sy;
        longint cy;
        longint sp;
        longint c;
        logic [63:0] sq;
        unity = longint'(1) << 28;
        w = q.quat_w;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        sr = 2 * (w * x + y * z);
        cr = unity - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = unity - 2 * (y * y + z * z);
        sp = 2 * (w * y - z * x);
        e.pitch_clamped = 1'b0;
        if (sp >= unity) begin
            e.pitch_angle = 16'sd16384;
            e.pitch_clamped = 1'b1;
        end
        else if (sp <= -unity) begin
            e.pitch_angle = -16'sd16384;
            e.pitch_clamped = 1'b1;
        end
        else begin
            sq = 64'(sp * sp);
            c = root_floor((64'd1 << 56) - sq);
            e.pitch_angle = angle16(vector_angle(sp, c));
        end
        e.roll_angle = angle16(vector_angle(sr, cr));
        e.yaw_angle  = angle16(vector_angle(sy, cy));
        return e;
    endfunction

    function void note_quat(qte_pkg::quat_t q);
        pending.push_back(predict_angles(q));
    endfunction

    task mismatch(string what);
        $display("MISMATCH %s at %0t", what, $time);
        mismatches++;
    endtask

    task check_euler(qte_pkg::euler_t got);
        qte_pkg::euler_t exp_e;
        if (pending.size() == 0) begin
            mismatch("unexpected result");
            return;
        end
        exp_e = pending.pop_front();
        if (got.roll_angle !== exp_e.roll_angle)
            mismatch($sformatf("roll %0d exp %0d", got.roll_angle, exp_e.roll_angle));
        if (got.pitch_angle !== exp_e.pitch_angle)
            mismatch($sformatf("pitch %0d exp %0d", got.pitch_angle, exp_e.pitch_angle));
        if (got.yaw_angle !== exp_e.yaw_angle)
            mismatch($sformatf("yaw %0d exp %0d", got.yaw_angle, exp_e.yaw_angle));
        if (got.pitch_clamped !== exp_e.pitch_clamped)
            mismatch($sformatf("clamp %0b exp %0b", got.pitch_clamped,
                               exp_e.pitch_clamped));
    endtask
endclass

module testbench;
    localparam int LATENCY = qte_pkg::NSTG;

    logic            clk;
    logic            rst_n;
    logic            quat_valid;
    logic            quat_stall;
    qte_pkg::quat_t  quat;
    logic            euler_valid;
    logic            euler_stall;
    qte_pkg::euler_t euler;

    euler_scoreboard board;

    // idle percentages, changed per phase
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;   // long receiver hold-off, counted by the stall process

    quaternion_to_euler_angles_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat       (quat),
        .euler_valid(euler_valid),
        .euler_stall(euler_stall),
        .euler      (euler)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Sends one quaternion; holds valid and payload until the transfer.
    // Valid stays high after the transfer until the next idle cycle or drain.
    task automatic send_quat(qte_pkg::quat_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            quat_valid <= 1'b0;
            @(posedge clk);
        end
        quat_valid <= 1'b1;
        quat <= q;
        @(posedge clk);
        while (quat_stall)
            @(posedge clk);
        board.note_quat(q);
    endtask

    // Rolled Q1.14 component: mostly in range, sometimes any 16-bit value.
    function automatic logic signed [15:0] rand_comp();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Roughly unit quaternion from a random direction, exercising real attitudes.
    function automatic qte_pkg::quat_t rand_unit_quat();
        qte_pkg::quat_t q;
        real a;
        real b;
        real c;
        real d;
        real n;
        a = $itor($signed($urandom_range(2000)) - 1000);
        b = $itor($signed($urandom_range(2000)) - 1000);
        c = $itor($signed($urandom_range(2000)) - 1000);
        d = $itor($signed($urandom_range(2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0)
        begin
            a = 1.0;
            n = 1.0;
        end
        q.quat_w = 16'($rtoi(a / n * 16384.0));
        q.quat_x = 16'($rtoi(b / n * 16384.0));
        q.quat_y = 16'($rtoi(c / n * 16384.0));
        q.quat_z = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    function automatic qte_pkg::quat_t mk(int w, int x, int y, int z);
        qte_pkg::quat_t q;
        q.quat_w = 16'(w);
        q.quat_x = 16'(x);
        q.quat_y = 16'(y);
        q.quat_z = 16'(z);
        return q;
    endfunction

    task automatic wait_drained();
        quat_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: send_quat(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
                // gimbal region: w = +/-y, x = z = 0 puts s = +/-2w^2 anywhere from zero to past one
                2: begin
                    int v;
                    v = $urandom_range(16384);
                    if ($urandom_range(1))
                        send_quat(mk(v, 0, v, 0));
                    else
                        send_quat(mk(v, 0, -v, 0));
                end
                default: send_quat(rand_unit_quat());
            endcase
        end
    endtask

    // Receiver: random stall, or a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            euler_stall <= 1'b0;
        else if (hold_off_cycles > 0) begin
            euler_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            euler_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every output transfer goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && euler_valid && !euler_stall)
            board.check_euler(euler);
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        quat_valid = 1'b0;
        quat = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identities, axis turns, extremes, degenerate atan2 cases
        send_quat(mk(16384, 0, 0, 0));
        send_quat(mk(-16384, 0, 0, 0));
        send_quat(mk(0, 16384, 0, 0));
        send_quat(mk(0, 0, 16384, 0));
        send_quat(mk(0, 0, 0, 16384));
        send_quat(mk(0, 0, 0, -16384));
        send_quat(mk(11585, 0, 11585, 0));      // pitch at +90
        send_quat(mk(11585, 0, -11585, 0));     // pitch at -90
        send_quat(mk(16384, 16384, 16384, -16384));
        send_quat(mk(-16384, -16384, -16384, -16384));
        send_quat(mk(0, 0, 0, 0));
        send_quat(mk(32767, 32767, 32767, 32767));
        send_quat(mk(-32768, -32768, -32768, -32768));
        send_quat(mk(-32768, 32767, -32768, 32767));
        send_quat(mk(0, 11585, 0, 11585));      // roll and yaw at zero, pitch near -90
        send_quat(mk(1, -11585, 0, 11585));
        send_quat(mk(16384, 0, 16384, 0));      // asin argument well past one
        send_quat(mk(16384, 16384, 0, 0));
        send_quat(mk(0, 0, 11585, -11585));
        send_quat(mk(5, 16384, 0, 0));
        send_quat(mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_quat(mk(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));

        random_phase(350, 0, 0);
        random_phase(300, 57, 0);
        random_phase(300, 0, 57);

        // long receiver hold-off while items keep coming, fills the pipeline
        hold_off_cycles = 3 * LATENCY;
        random_phase(150, 0, 0);

        // sender pauses until everything has drained
        wait_drained();
        random_phase(400, 13, 13);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
